FILE: design/bsdr_pkg.sv
// ----------------------------------------------------------------------------
// bsdr_pkg
// Shared types and fixed constants for the ball sprite dirty-rectangle redraw
// core: the position and run words, the shared unit's command and run codes.
// ----------------------------------------------------------------------------
package bsdr_pkg;

    // Rows of one display page and the fixed widths of internal row/page values.
    localparam int PAGE_ROWS = 8;
    localparam int ROW_W     = 7;   // ball row bound, at most 63 + 3
    localparam int PAGE_W    = 4;   // page index of a row bound, at most 8
    localparam int ALU_W     = 9;   // shared unit operand width
    localparam int MAX_RUNS  = 24;  // most runs one position may cause
    localparam int CNT_W     = 5;   // run counter, 0 .. MAX_RUNS

    typedef struct packed {
        logic [6:0] ball_x;
        logic [5:0] ball_y;
    } pos_t;

    typedef struct packed {
        logic [2:0] page;
        logic [6:0] first_col;
        logic [6:0] last_col;
        logic [7:0] pattern;
        logic       last_run;
    } run_t;

    // Shared unit operations.
    typedef enum logic [1:0] {
        OP_LO  = 2'd0,  // saturating a - b, then held to lim
        OP_HI  = 2'd1,  // a + b, then held to lim
        OP_MIN = 2'd2,
        OP_MAX = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
        logic [ALU_W-1:0]   lim;
    } alu_cmd_t;

    // Kind of run within one page.
    typedef enum logic [1:0] {
        K_LEFT  = 2'd0,
        K_BALL  = 2'd1,
        K_RIGHT = 2'd2
    } run_kind_t;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LEFT   = 9'b000000010,
        S_RIGHT  = 9'b000000100,
        S_TOP    = 9'b000001000,
        S_BOT    = 9'b000010000,
        S_BLEFT  = 9'b000100000,
        S_BRIGHT = 9'b001000000,
        S_PFIRST = 9'b010000000,
        S_PLAST  = 9'b100000000
    } seq_state_t;

    // Emission is its own state, kept apart so the setup steps stay one-hot above.
    localparam logic EMIT_ON = 1'b1;

endpackage

FILE: design/bsdr_alu.sv
// ----------------------------------------------------------------------------
// bsdr_alu
// Shared add/subtract/compare unit: clamped bounds, minimum and maximum.
// ----------------------------------------------------------------------------
module bsdr_alu
    import bsdr_pkg::*;
(
    input  alu_cmd_t            cmd,
    output logic [ALU_W-1:0]    y
);

    logic [ALU_W-1:0] sum;
    logic [ALU_W-1:0] diff;

    always_comb
    begin
        sum  = cmd.a + cmd.b;
        diff = (cmd.a >= cmd.b) ? (cmd.a - cmd.b) : '0;
        unique case (cmd.op)
            OP_LO:   y = (diff > cmd.lim) ? cmd.lim : diff;
            OP_HI:   y = (sum > cmd.lim) ? cmd.lim : sum;
            OP_MIN:  y = (cmd.a < cmd.b) ? cmd.a : cmd.b;
            OP_MAX:  y = (cmd.a > cmd.b) ? cmd.a : cmd.b;
            default: y = '0;
        endcase
    end

endmodule

FILE: design/bsdr_mask.sv
// ----------------------------------------------------------------------------
// bsdr_mask
// Vertical bit mask of the ball on one page; zero on pages the ball misses.
// ----------------------------------------------------------------------------
module bsdr_mask
    import bsdr_pkg::*;
(
    input  logic [PAGE_W-1:0]   page,
    input  logic [ROW_W-1:0]    top_row,
    input  logic [ROW_W-1:0]    bot_row,
    output logic [7:0]          pattern
);

    logic [PAGE_W-1:0] top_pg;
    logic [PAGE_W-1:0] bot_pg;
    logic              in_span;
    logic [2:0]        lo;
    logic [2:0]        hi;

    always_comb
    begin
        top_pg  = PAGE_W'(top_row >> 3);
        bot_pg  = PAGE_W'(bot_row >> 3);
        in_span = (page >= top_pg) && (page <= bot_pg);
        // Clip the row span to this page.
        lo = (page == top_pg) ? top_row[2:0] : 3'd0;
        hi = (page == bot_pg) ? bot_row[2:0] : 3'd7;
        for (int i = 0; i < PAGE_ROWS; i++)
        begin
            pattern[i] = in_span && (3'(i) >= lo) && (3'(i) <= hi);
        end
    end

endmodule

FILE: design/ball_sprite_dirty_rect_redraw_core.sv
// ----------------------------------------------------------------------------
// ball_sprite_dirty_rect_redraw_core
// Turns each new ball position into fill runs for a page-addressed display.
// ----------------------------------------------------------------------------
// Usage:
//   pos channel (pos_valid/pos_ready/pos) takes one word per ball update with
//   the new centre column and row. run channel (run_valid/run_ready/run)
//   returns the fill runs for that update: per page of the union of the old
//   and new page spans, zeros left of the ball, the ball mask, zeros right of
//   the ball; empty side runs are dropped. last_run marks the final word.
//   Flow: after a word is accepted, the setup steps (left, right, top, bottom,
//   union left, union right, first page, last page) run the clamps and the
//   union bounds through one shared add/compare unit; then one run word per
//   cycle while the receiver takes them, at most 24. A new position is not
//   taken until the final run word of the last one has been built:
//   pos_ready is high only while neither setup nor emission runs.
//   The run word sits in an output register: on stall (run_ready low) hold
//   it and the sequencer; the next word is built as soon as it is taken.
//   Reset clears the stored bounds to page 0, column 0, so the first update
//   also clears page 0 from column 0.
// ----------------------------------------------------------------------------
module ball_sprite_dirty_rect_redraw_core
    import bsdr_pkg::*;
#(
    parameter int BALL_RADIUS     = 2,
    parameter int DISPLAY_COLUMNS = 128,
    parameter int DISPLAY_PAGES   = 8
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pos_valid,
    output logic    pos_ready,
    input  pos_t    pos,
    output logic    run_valid,
    input  logic    run_ready,
    output run_t    run
);

    localparam int COL_W = $clog2(DISPLAY_COLUMNS);
    localparam logic [ALU_W-1:0] RADIUS  = ALU_W'(BALL_RADIUS);
    localparam logic [ALU_W-1:0] COL_LIM = ALU_W'(DISPLAY_COLUMNS - 1);
    localparam logic [ALU_W-1:0] ROW_LIM = ALU_W'(DISPLAY_PAGES * PAGE_ROWS - 1);

    // Control state.
    seq_state_t         state_reg, state_next;
    logic               emit_reg, emit_next;
    run_kind_t          kind_reg, kind_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PAGE_W-1:0]  page_reg, page_next;
    logic               run_valid_reg, run_valid_next;

    // Stored bounds of the previous ball.
    logic [COL_W-1:0]   prev_left_reg, prev_left_next;
    logic [COL_W-1:0]   prev_right_reg, prev_right_next;
    logic [PAGE_W-1:0]  prev_top_reg, prev_top_next;
    logic [PAGE_W-1:0]  prev_bot_reg, prev_bot_next;

    // Working bounds of this update.
    pos_t               pos_reg, pos_next;
    logic [COL_W-1:0]   left_reg, left_next;
    logic [COL_W-1:0]   right_reg, right_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [ROW_W-1:0]   bot_reg, bot_next;
    logic [COL_W-1:0]   b_left_reg, b_left_next;
    logic [COL_W-1:0]   b_right_reg, b_right_next;
    logic [PAGE_W-1:0]  pg_last_reg, pg_last_next;
    run_t               run_reg, run_next;

    alu_cmd_t           cmd;
    logic [ALU_W-1:0]   alu_y;
    logic [7:0]         pattern;
    logic               has_left;
    logic               has_right;
    logic               page_end;
    logic               final_run;
    logic               fire;
    logic [COL_W-1:0]   first_c;
    logic [COL_W-1:0]   last_c;
    logic [7:0]         pat_c;

    bsdr_alu u_alu
    (
        .cmd (cmd),
        .y   (alu_y)
    );

    bsdr_mask u_mask
    (
        .page    (page_reg),
        .top_row (top_reg),
        .bot_row (bot_reg),
        .pattern (pattern)
    );

    assign pos_ready = (state_reg == S_IDLE) && !emit_reg;
    assign run_valid = run_valid_reg;
    assign run       = run_reg;

    // Feed the shared unit according to the setup step.
    always_comb
    begin
        cmd.op  = OP_LO;
        cmd.a   = '0;
        cmd.b   = RADIUS;
        cmd.lim = COL_LIM;
        unique case (state_reg)
            S_LEFT:
            begin
                cmd.op = OP_LO;
                cmd.a  = ALU_W'(pos_reg.ball_x);
            end
            S_RIGHT:
            begin
                cmd.op = OP_HI;
                cmd.a  = ALU_W'(pos_reg.ball_x);
            end
            S_TOP:
            begin
                cmd.op  = OP_LO;
                cmd.a   = ALU_W'(pos_reg.ball_y);
                cmd.lim = ROW_LIM;
            end
            S_BOT:
            begin
                cmd.op  = OP_HI;
                cmd.a   = ALU_W'(pos_reg.ball_y);
                cmd.lim = ROW_LIM;
            end
            S_BLEFT:
            begin
                cmd.op = OP_MIN;
                cmd.a  = ALU_W'(prev_left_reg);
                cmd.b  = ALU_W'(left_reg);
            end
            S_BRIGHT:
            begin
                cmd.op = OP_MAX;
                cmd.a  = ALU_W'(prev_right_reg);
                cmd.b  = ALU_W'(right_reg);
            end
            S_PFIRST:
            begin
                cmd.op = OP_MIN;
                cmd.a  = ALU_W'(prev_top_reg);
                cmd.b  = ALU_W'(top_reg >> 3);
            end
            S_PLAST:
            begin
                cmd.op = OP_MAX;
                cmd.a  = ALU_W'(prev_bot_reg);
                cmd.b  = ALU_W'(bot_reg >> 3);
            end
            S_IDLE:
            begin
                cmd.op = OP_LO;
            end
            default:
            begin
                cmd.op = OP_LO;
            end
        endcase
    end

    // Shape the current run.
    always_comb
    begin
        has_left  = b_left_reg < left_reg;
        has_right = right_reg < b_right_reg;
        page_end  = (kind_reg == K_RIGHT) || ((kind_reg == K_BALL) && !has_right);
        final_run = (page_end && (page_reg == pg_last_reg))
                    || (cnt_reg == CNT_W'(MAX_RUNS - 1));
        fire      = emit_reg && (!run_valid_reg || run_ready);
        unique case (kind_reg)
            K_LEFT:
            begin
                first_c = b_left_reg;
                last_c  = left_reg - 1'b1;
                pat_c   = '0;
            end
            K_BALL:
            begin
                first_c = left_reg;
                last_c  = right_reg;
                pat_c   = pattern;
            end
            K_RIGHT:
            begin
                first_c = right_reg + 1'b1;
                last_c  = b_right_reg;
                pat_c   = '0;
            end
            default:
            begin
                first_c = left_reg;
                last_c  = right_reg;
                pat_c   = '0;
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        emit_next       = emit_reg;
        kind_next       = kind_reg;
        cnt_next        = cnt_reg;
        page_next       = page_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        prev_top_next   = prev_top_reg;
        prev_bot_next   = prev_bot_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        top_next        = top_reg;
        bot_next        = bot_reg;
        b_left_next     = b_left_reg;
        b_right_next    = b_right_reg;
        pg_last_next    = pg_last_reg;
        run_next        = run_reg;
        run_valid_next  = run_valid_reg && !run_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pos_valid && pos_ready)
                begin
                    pos_next   = pos;
                    state_next = S_LEFT;
                end
            end
            S_LEFT:
            begin
                left_next  = COL_W'(alu_y);
                state_next = S_RIGHT;
            end
            S_RIGHT:
            begin
                right_next = COL_W'(alu_y);
                state_next = S_TOP;
            end
            S_TOP:
            begin
                top_next   = ROW_W'(alu_y);
                state_next = S_BOT;
            end
            S_BOT:
            begin
                bot_next   = ROW_W'(alu_y);
                state_next = S_BLEFT;
            end
            S_BLEFT:
            begin
                b_left_next = COL_W'(alu_y);
                state_next  = S_BRIGHT;
            end
            S_BRIGHT:
            begin
                b_right_next = COL_W'(alu_y);
                state_next   = S_PFIRST;
            end
            S_PFIRST:
            begin
                page_next  = PAGE_W'(alu_y);
                state_next = S_PLAST;
            end
            S_PLAST:
            begin
                // All old bounds are consumed; commit the new ones.
                pg_last_next    = PAGE_W'(alu_y);
                prev_left_next  = left_reg;
                prev_right_next = right_reg;
                prev_top_next   = PAGE_W'(top_reg >> 3);
                prev_bot_next   = PAGE_W'(bot_reg >> 3);
                kind_next       = has_left ? K_LEFT : K_BALL;
                cnt_next        = '0;
                emit_next       = EMIT_ON;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fire)
        begin
            run_next.page      = 3'(page_reg);
            run_next.first_col = 7'(first_c);
            run_next.last_col  = 7'(last_c);
            run_next.pattern   = pat_c;
            run_next.last_run  = final_run;
            run_valid_next     = 1'b1;
            cnt_next           = cnt_reg + 1'b1;
            priority if (final_run)
            begin
                emit_next = 1'b0;
            end
            else if (page_end)
            begin
                page_next = page_reg + 1'b1;
                kind_next = has_left ? K_LEFT : K_BALL;
            end
            else if (kind_reg == K_LEFT)
            begin
                kind_next = K_BALL;
            end
            else
            begin
                kind_next = K_RIGHT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            emit_reg       <= 1'b0;
            kind_reg       <= K_LEFT;
            cnt_reg        <= '0;
            page_reg       <= '0;
            run_valid_reg  <= 1'b0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_top_reg   <= '0;
            prev_bot_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            emit_reg       <= emit_next;
            kind_reg       <= kind_next;
            cnt_reg        <= cnt_next;
            page_reg       <= page_next;
            run_valid_reg  <= run_valid_next;
            prev_left_reg  <= prev_left_next;
            prev_right_reg <= prev_right_next;
            prev_top_reg   <= prev_top_next;
            prev_bot_reg   <= prev_bot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        top_reg     <= top_next;
        bot_reg     <= bot_next;
        b_left_reg  <= b_left_next;
        b_right_reg <= b_right_next;
        pg_last_reg <= pg_last_next;
        run_reg     <= run_next;
    end

`ifndef SYNTHESIS
    // Every emitted run spans at least one column.
    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (first_c <= last_c))
        else $error("run with first column past last column");

    // An accepted position starts the clamp steps.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_valid && pos_ready) |=> (state_reg == S_LEFT))
        else $error("accepted position did not start setup");

    // Emission never walks past the last page of the union.
    a_page_span: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> (page_reg <= pg_last_reg))
        else $error("page counter past last page");

    // Setup and emission never overlap.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> (state_reg == S_IDLE))
        else $error("emission during setup");

    // A final run ends emission.
    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && final_run) |=> !emit_reg)
        else $error("emission continued after final run");
`endif

endmodule
